// ===== rtl/core/qbz_pkg.sv =====
package qbz_pkg;

  // Coordinate format: signed, 8 fraction bits.
  localparam int COORD_W = 24;

  // Curve parameter t: unsigned, 16 fraction bits.
  localparam int T_FRAC = 16;

  // Samples taken per control-point set.
  localparam int SAMPLES = 16;

  // Sample counter width (at least one bit).
  localparam int K_W = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;

  // The t increment is split into a whole step and a remainder modulo SAMPLES.
  localparam int TQ_STEP = (1 << T_FRAC) / SAMPLES;
  localparam int TQ_REM  = (1 << T_FRAC) % SAMPLES;

  // The remainder accumulator must hold values below twice SAMPLES.
  localparam int REM_W = $clog2(SAMPLES) + 1;

  // Lerp product width: 25-bit difference times 17-bit signed t.
  localparam int DIFF_W = COORD_W + 1;
  localparam int PROD_W = DIFF_W + T_FRAC + 1;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [T_FRAC-1:0]         tq_t;

  // Per-sample control that travels down the pipeline with the data.
  typedef struct packed {
    logic vld;
    logic last;
    tq_t  tq;
  } smp_ctl_t;

endpackage

// ===== rtl/core/qbz_lerp.sv =====
// One interpolation step: y = a + floor((b - a) * t / 2^16).
module qbz_lerp (
  input  qbz_pkg::coord_t a,
  input  qbz_pkg::coord_t b,
  input  qbz_pkg::tq_t    tq,
  output qbz_pkg::coord_t y
);

  logic signed [qbz_pkg::DIFF_W-1:0]   diff;
  logic signed [qbz_pkg::PROD_W-1:0]   prod;
  logic signed [qbz_pkg::PROD_W-qbz_pkg::T_FRAC-1:0] step;
  logic signed [qbz_pkg::PROD_W-qbz_pkg::T_FRAC-1:0] sum;

  // Difference of the two operands, one bit wider so it cannot wrap.
  assign diff = $signed({b[qbz_pkg::COORD_W-1], b}) - $signed({a[qbz_pkg::COORD_W-1], a});

  // Exact product; t is zero-extended to make it a positive signed value.
  assign prod = qbz_pkg::PROD_W'(diff) * qbz_pkg::PROD_W'($signed({1'b0, tq}));

  // Dropping the fraction bits of a two's complement value rounds toward minus infinity.
  assign step = prod[qbz_pkg::PROD_W-1:qbz_pkg::T_FRAC];

  // The result lies between a and b, so the low bits carry the full value.
  assign sum = $bits(sum)'(a) + step;
  assign y   = sum[qbz_pkg::COORD_W-1:0];

endmodule

// ===== rtl/core/qbz_seq.sv =====
// Holds the control points of the current transaction and issues one sample per cycle.
module qbz_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  qbz_pkg::coord_t     pts_i [2][5],
  output qbz_pkg::coord_t     pts_o [2][5],
  output qbz_pkg::smp_ctl_t   ctl_o
);

  logic                       active_r, active_nxt;
  logic [qbz_pkg::K_W-1:0]    k_r, k_nxt;
  qbz_pkg::tq_t               tq_r, tq_nxt;
  logic [qbz_pkg::REM_W-1:0]  rem_r, rem_nxt;
  logic [qbz_pkg::REM_W-1:0]  rem_sum;
  logic                       rem_carry;
  logic [qbz_pkg::T_FRAC:0]   tq_sum;
  logic                       last_k;
  logic                       accept;
  qbz_pkg::coord_t            pts_r [2][5];

  assign last_k = (k_r == qbz_pkg::K_W'(qbz_pkg::SAMPLES - 1));

  // A new transaction may start in the cycle that issues the final sample.
  assign busy   = active_r && !last_k;
  assign accept = start && !busy;

  // Next t = floor((k+1) * 2^16 / SAMPLES), kept as quotient and remainder.
  assign rem_sum   = rem_r + qbz_pkg::REM_W'(qbz_pkg::TQ_REM);
  assign rem_carry = (rem_sum >= qbz_pkg::REM_W'(qbz_pkg::SAMPLES));
  assign tq_sum    = (qbz_pkg::T_FRAC+1)'(tq_r) + (qbz_pkg::T_FRAC+1)'(qbz_pkg::TQ_STEP)
                   + (qbz_pkg::T_FRAC+1)'(rem_carry);

  // Sample counter and t accumulator.
  always_comb begin
    active_nxt = active_r;
    k_nxt      = k_r;
    tq_nxt     = tq_r;
    rem_nxt    = rem_r;
    priority if (accept) begin
      active_nxt = 1'b1;
      k_nxt      = '0;
      tq_nxt     = '0;
      rem_nxt    = '0;
    end else if (active_r) begin
      if (last_k) begin
        active_nxt = 1'b0;
      end else begin
        k_nxt   = qbz_pkg::K_W'(k_r + 1'b1);
        tq_nxt  = tq_sum[qbz_pkg::T_FRAC-1:0];
        rem_nxt = rem_carry ? qbz_pkg::REM_W'(rem_sum - qbz_pkg::REM_W'(qbz_pkg::SAMPLES))
                            : rem_sum;
      end
    end else begin
      // Idle with no new transaction: the sequencer stays inactive.
      active_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      k_r      <= '0;
      tq_r     <= '0;
      rem_r    <= '0;
    end else begin
      active_r <= active_nxt;
      k_r      <= k_nxt;
      tq_r     <= tq_nxt;
      rem_r    <= rem_nxt;
    end
  end

  // Control points are captured with each accepted transaction.
  always_ff @(posedge clk) begin
    if (accept) begin
      pts_r <= pts_i;
    end
  end

  assign pts_o     = pts_r;
  assign ctl_o.vld  = active_r;
  assign ctl_o.last = last_k;
  assign ctl_o.tq   = tq_r;

endmodule

// ===== rtl/core/qbz_dp.sv =====
// Four registered de Casteljau levels for x and y; one new sample may enter every cycle.
module qbz_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  qbz_pkg::coord_t    pts_i [2][5],
  input  qbz_pkg::smp_ctl_t  ctl_i,
  output qbz_pkg::coord_t    res_o [2],
  output qbz_pkg::smp_ctl_t  ctl_o
);

  qbz_pkg::coord_t   l1_nxt [2][4];
  qbz_pkg::coord_t   l1_r   [2][4];
  qbz_pkg::coord_t   l2_nxt [2][3];
  qbz_pkg::coord_t   l2_r   [2][3];
  qbz_pkg::coord_t   l3_nxt [2][2];
  qbz_pkg::coord_t   l3_r   [2][2];
  qbz_pkg::coord_t   l4_nxt [2];
  qbz_pkg::coord_t   l4_r   [2];
  qbz_pkg::smp_ctl_t c1_r, c2_r, c3_r, c4_r;

  // Interpolators of all four levels, for both axes.
  for (genvar ax = 0; ax < 2; ax++) begin : g_axis
    for (genvar i = 0; i < 4; i++) begin : g_l1
      qbz_lerp u_lerp (.a(pts_i[ax][i]), .b(pts_i[ax][i+1]), .tq(ctl_i.tq),
                       .y(l1_nxt[ax][i]));
    end
    for (genvar i = 0; i < 3; i++) begin : g_l2
      qbz_lerp u_lerp (.a(l1_r[ax][i]), .b(l1_r[ax][i+1]), .tq(c1_r.tq),
                       .y(l2_nxt[ax][i]));
    end
    for (genvar i = 0; i < 2; i++) begin : g_l3
      qbz_lerp u_lerp (.a(l2_r[ax][i]), .b(l2_r[ax][i+1]), .tq(c2_r.tq),
                       .y(l3_nxt[ax][i]));
    end
    qbz_lerp u_l4 (.a(l3_r[ax][0]), .b(l3_r[ax][1]), .tq(c3_r.tq), .y(l4_nxt[ax]));
  end

  // Stage registers: the valid bits are reset, the payload of partial points,
  // t and the last-sample flag is not.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_r.vld <= 1'b0;
      c2_r.vld <= 1'b0;
      c3_r.vld <= 1'b0;
      c4_r.vld <= 1'b0;
    end else begin
      c1_r.vld <= ctl_i.vld;
      c2_r.vld <= c1_r.vld;
      c3_r.vld <= c2_r.vld;
      c4_r.vld <= c3_r.vld;
    end
    c1_r.last <= ctl_i.last;
    c1_r.tq   <= ctl_i.tq;
    c2_r.last <= c1_r.last;
    c2_r.tq   <= c1_r.tq;
    c3_r.last <= c2_r.last;
    c3_r.tq   <= c2_r.tq;
    c4_r.last <= c3_r.last;
    c4_r.tq   <= c3_r.tq;
    l1_r      <= l1_nxt;
    l2_r      <= l2_nxt;
    l3_r      <= l3_nxt;
    l4_r      <= l4_nxt;
  end

  assign res_o = l4_r;
  assign ctl_o = c4_r;

endmodule

// ===== rtl/core/quartic_bezier_sampler_top.sv =====
// The first sample is registered in the sequencer and in each de Casteljau level.
// Each transaction yields SAMPLES results, one per cycle, in order of increasing t.
// Transactions are paced by the sample sequencer; the next transaction is taken in the
// cycle that issues the final sample of the current one.
// Reset (rst_n low, synchronous) clears the sequencer and all pipeline valid bits.
// Results are strobed by out_valid for one cycle; the receiver cannot stall them.
module quartic_bezier_sampler_top (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  qbz_pkg::coord_t in_p0_x,
  input  qbz_pkg::coord_t in_p0_y,
  input  qbz_pkg::coord_t in_p1_x,
  input  qbz_pkg::coord_t in_p1_y,
  input  qbz_pkg::coord_t in_p2_x,
  input  qbz_pkg::coord_t in_p2_y,
  input  qbz_pkg::coord_t in_p3_x,
  input  qbz_pkg::coord_t in_p3_y,
  input  qbz_pkg::coord_t in_p4_x,
  input  qbz_pkg::coord_t in_p4_y,
  output logic            out_valid,
  output qbz_pkg::coord_t out_curve_x,
  output qbz_pkg::coord_t out_curve_y,
  output logic            out_last_sample
);

  qbz_pkg::coord_t   pts_in  [2][5];
  qbz_pkg::coord_t   pts_cur [2][5];
  qbz_pkg::coord_t   res     [2];
  qbz_pkg::smp_ctl_t smp_ctl;
  qbz_pkg::smp_ctl_t res_ctl;

  // Gather the control points by axis: index 0 is x, index 1 is y.
  assign pts_in[0][0] = in_p0_x;
  assign pts_in[1][0] = in_p0_y;
  assign pts_in[0][1] = in_p1_x;
  assign pts_in[1][1] = in_p1_y;
  assign pts_in[0][2] = in_p2_x;
  assign pts_in[1][2] = in_p2_y;
  assign pts_in[0][3] = in_p3_x;
  assign pts_in[1][3] = in_p3_y;
  assign pts_in[0][4] = in_p4_x;
  assign pts_in[1][4] = in_p4_y;

  qbz_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .pts_i (pts_in),
    .pts_o (pts_cur),
    .ctl_o (smp_ctl)
  );

  qbz_dp u_dp (
    .clk   (clk),
    .rst_n (rst_n),
    .pts_i (pts_cur),
    .ctl_i (smp_ctl),
    .res_o (res),
    .ctl_o (res_ctl)
  );

  assign out_valid       = res_ctl.vld;
  assign out_last_sample = res_ctl.last;
  assign out_curve_x     = res[0];
  assign out_curve_y     = res[1];

`ifndef SYNTHESIS
  // An accepted transaction produces its first sample after the full pipeline latency.
  a_first_sample: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##5 out_valid)
    else $error("first sample missing after start transaction");

  // While busy, a non-final sample is in flight and later leaves the last pipeline level.
  a_busy_sample: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> ##4 (out_valid && !out_last_sample))
    else $error("busy without a matching non-final sample");

  // The final sample was issued in a cycle where a new transaction could be taken.
  a_last_free: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_sample) |-> $past(!busy, 4))
    else $error("final sample issued while busy");
`endif

endmodule

// ===== verif/quartic_bezier_sampler_top_tb.sv =====
module quartic_bezier_sampler_top_tb;
  typedef qbz_pkg::coord_t coord_t;

  localparam coord_t COORD_MAX = 24'sh7FFFFF;
  localparam coord_t COORD_MIN = 24'sh800000;
  localparam int RANDOM_ITEMS = 146;
  // Idling stops for the last stretch of random transactions.
  localparam int QUIET_TAIL = 30;
  localparam int CYCLE_LIMIT = 200000;

  // Expected curve samples for accepted control-point sets, checked in order.
  class curve_sample_scoreboard;
    typedef struct {
      coord_t x;
      coord_t y;
      logic   last;
    } curve_sample_t;

    curve_sample_t expected_samples[$];
    int unsigned   mismatches = 0;

    // One de Casteljau lerp step; the arithmetic shift floors the product.
    function automatic longint lerp_q16(longint a, longint b, longint tq);
      return a + (((b - a) * tq) >>> qbz_pkg::T_FRAC);
    endfunction

    // Four levels of lerps over one axis of the five control points.
    function automatic longint eval_axis(coord_t [4:0] c, longint tq);
      longint w[5];
      for (int i = 0; i < 5; i++) w[i] = c[i];
      for (int lvl = 4; lvl > 0; lvl--) begin
        for (int i = 0; i < lvl; i++) w[i] = lerp_q16(w[i], w[i+1], tq);
      end
      return w[0];
    endfunction

    // Queue the SAMPLES points of one accepted transaction.
    function void note_control_points(coord_t [4:0] cx, coord_t [4:0] cy);
      curve_sample_t s;
      longint tq;
      for (longint k = 0; k < qbz_pkg::SAMPLES; k++) begin
        tq = (k << qbz_pkg::T_FRAC) / qbz_pkg::SAMPLES;
        s.x = coord_t'(eval_axis(cx, tq));
        s.y = coord_t'(eval_axis(cy, tq));
        s.last = (k == qbz_pkg::SAMPLES - 1);
        expected_samples.insert(expected_samples.size(), s);
      end
    endfunction

    // Compare one strobed result with the oldest expected sample.
    function void check_sample(coord_t x, coord_t y, logic last);
      curve_sample_t s;
      if (expected_samples.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected sample: x=%0d y=%0d last=%b", x, y, last);
        mismatches++;
        return;
      end
      s = expected_samples.pop_front();
      if (x !== s.x || y !== s.y || last !== s.last) begin
        if (mismatches < 10)
          $display("sample mismatch: expected x=%0d y=%0d last=%b, got x=%0d y=%0d last=%b",
                   s.x, s.y, s.last, x, y, last);
        mismatches++;
      end
    endfunction

    function int pending();
      return expected_samples.size();
    endfunction
  endclass

  logic   clk = 1'b0;
  logic   rst_n = 1'b0;
  logic   start = 1'b0;
  logic   busy;
  coord_t in_p0_x = '0, in_p0_y = '0, in_p1_x = '0, in_p1_y = '0, in_p2_x = '0;
  coord_t in_p2_y = '0, in_p3_x = '0, in_p3_y = '0, in_p4_x = '0, in_p4_y = '0;
  logic   out_valid;
  coord_t out_curve_x, out_curve_y;
  logic   out_last_sample;

  curve_sample_scoreboard sb;
  int unsigned cycles = 0;

  quartic_bezier_sampler_top i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_p0_x         (in_p0_x),
    .in_p0_y         (in_p0_y),
    .in_p1_x         (in_p1_x),
    .in_p1_y         (in_p1_y),
    .in_p2_x         (in_p2_x),
    .in_p2_y         (in_p2_y),
    .in_p3_x         (in_p3_x),
    .in_p3_y         (in_p3_y),
    .in_p4_x         (in_p4_x),
    .in_p4_y         (in_p4_y),
    .out_valid       (out_valid),
    .out_curve_x     (out_curve_x),
    .out_curve_y     (out_curve_y),
    .out_last_sample (out_last_sample)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Results cannot be held off, so every strobe is checked at its closing edge.
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1)
      sb.check_sample(out_curve_x, out_curve_y, out_last_sample);
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("quartic_bezier_sampler_top_tb: done, errors");
      $finish;
    end
  end

  // Present one control-point set and hold it until the start transaction is taken.
  task automatic send_points(input coord_t [4:0] cx, input coord_t [4:0] cy);
    in_p0_x <= cx[0]; in_p0_y <= cy[0];
    in_p1_x <= cx[1]; in_p1_y <= cy[1];
    in_p2_x <= cx[2]; in_p2_y <= cy[2];
    in_p3_x <= cx[3]; in_p3_y <= cy[3];
    in_p4_x <= cx[4]; in_p4_y <= cy[4];
    start <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    sb.note_control_points(cx, cy);
  endtask

  task automatic idle_for(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Random coordinate: full range, near zero, or a pick of extremes, zero, minus one or full range.
  function automatic coord_t rand_coord(input int mode);
    case (mode)
      0: return coord_t'($urandom);
      1: return coord_t'(int'($urandom_range(0, 2047)) - 1024);
      default: begin
        case ($urandom_range(0, 4))
          0: return COORD_MAX;
          1: return COORD_MIN;
          2: return '0;
          3: return -24'sd1;
          default: return coord_t'($urandom);
        endcase
      end
    endcase
  endfunction

  initial begin : stimulus
    coord_t [4:0] cx, cy;
    int mode;

    sb = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed sets: extremes, sign flips, floor rounding, single points and one random set.
    for (int d = 0; d < 14; d++) begin
      for (int i = 0; i < 5; i++) begin
        case (d)
          0: begin cx[i] = '0; cy[i] = '0; end
          1: begin cx[i] = COORD_MAX; cy[i] = COORD_MAX; end
          2: begin cx[i] = COORD_MIN; cy[i] = COORD_MIN; end
          3: begin
            cx[i] = (i % 2) ? COORD_MAX : COORD_MIN;
            cy[i] = (i % 2) ? COORD_MIN : COORD_MAX;
          end
          4: begin
            cx[i] = (i == 0) ? COORD_MIN : (i == 4) ? COORD_MAX : '0;
            cy[i] = (i == 0) ? COORD_MAX : (i == 4) ? COORD_MIN : '0;
          end
          5: begin cx[i] = -24'sd1; cy[i] = 24'sd1; end
          6: begin cx[i] = coord_t'(i); cy[i] = coord_t'(-i); end
          7: begin
            cx[i] = (i % 2) ? -24'sd1 : 24'sd1;
            cy[i] = (i % 2) ? 24'sd3 : -24'sd3;
          end
          8, 9, 10, 11, 12: begin
            cx[i] = (i == d - 8) ? COORD_MAX : '0;
            cy[i] = (i == d - 8) ? COORD_MIN : '0;
          end
          default: begin cx[i] = rand_coord(0); cy[i] = rand_coord(0); end
        endcase
      end
      send_points(cx, cy);
      if (d % 4 == 3) idle_for($urandom_range(1, 19));
    end

    // Random sets with bursts of idling, then a quiet tail.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // Let the block drain completely once mid-run.
      if (n == RANDOM_ITEMS / 2) begin
        start <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
      end
      mode = $urandom_range(0, 9);
      mode = (mode < 6) ? 0 : (mode < 8) ? 1 : 2;
      for (int i = 0; i < 5; i++) begin
        cx[i] = rand_coord(mode);
        cy[i] = rand_coord(mode);
      end
      send_points(cx, cy);
      if (n < RANDOM_ITEMS - QUIET_TAIL && $urandom_range(0, 3) == 0)
        idle_for($urandom_range(1, 19));
    end
    start <= 1'b0;

    // Wait for the outstanding samples, then idle for longer than the pipeline latency.
    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.mismatches == 0)
      $display("quartic_bezier_sampler_top_tb: done, clean");
    else
      $display("quartic_bezier_sampler_top_tb: done, errors");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/qbz_pkg.sv
rtl/core/qbz_lerp.sv
rtl/core/qbz_seq.sv
rtl/core/qbz_dp.sv
rtl/core/quartic_bezier_sampler_top.sv
verif/quartic_bezier_sampler_top_tb.sv
